/* sv/rectangle_paint_engine_assert.svh */
// assertion macros for the rectangle paint engine
// expects clk and rst in the scope of the module that uses them
`ifndef RECTANGLE_PAINT_ENGINE_ASSERT_SVH
`define RECTANGLE_PAINT_ENGINE_ASSERT_SVH

// condition holds in the same cycle
`define RPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define RPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rpe_pkg.sv */
// types and constants shared by the rectangle paint engine
// no dependencies
`timescale 1ns / 1ps

package rpe_pkg;

  localparam int MAX_COLS_DEF  = 256;
  localparam int MAX_ROWS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int POS_W     = 20;
  localparam int CHAR_W    = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_REJECT  = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_CHAR = 2'd2;

  localparam logic [CHAR_W-1:0] SHAPE_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h72;

  localparam logic [CFG_W-1:0]  CANVAS_WIDTH_RST    = 9'd256;
  localparam logic [CFG_W-1:0]  CANVAS_HEIGHT_RST   = 9'd256;
  localparam logic [CHAR_W-1:0] BACKGROUND_CHAR_RST = 8'd32;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [CHAR_W-1:0]       shape_code;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] rect_width;
    logic signed [POS_W-1:0] rect_height;
    logic [CHAR_W-1:0]       paint_char;
    logic [7:0]              read_col;
    logic [7:0]              read_row;
  } rpe_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] cell_value;
  } rpe_rsp_t;

endpackage

/* sv/rectangle_paint_engine.sv */
// rectangle paint engine: character canvas with clear, rectangle draw and cell read
// depends on rpe_pkg and rectangle_paint_engine_assert.svh
`timescale 1ns / 1ps
//
// usage
//   req channel (req_valid/req_ready/req) takes one command item; rsp channel
//   (rsp_valid/rsp_ready/rsp) returns one item of status and cell value for each item
//   cfg_we/cfg_index/cfg_data writes canvas width, height and background char; the
//   user must write them only while the engine is idle; no logic in the engine checks this
//   one command is worked on at a time; req_ready is high only when idle
//   clear and accepted draw: one canvas cell per cycle through the single
//   write port of the canvas memory, sweeping all cols*rows cells of the canvas
//   in use; read: one registered memory read; rejected draw, read outside
//   the canvas, an empty canvas and the unused command go straight to finish
//   the result sits in an output register; the engine returns to idle and
//   takes the next item while it waits, and stalls only if a second result is
//   ready before the first is taken
//   reset (rst, synchronous) restores the register defaults and empties the
//   output register; canvas contents are undefined until a clear, and there
//   is no clearing pass after reset
//
module rectangle_paint_engine
  import rpe_pkg::*;
#(
  parameter int MAX_COLS  = MAX_COLS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  rpe_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rpe_rsp_t             rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CIW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RIW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW      = CIW + RIW;
  localparam int DEPTH   = 2 ** AW;
  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int SZ_W    = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int IW      = (CIW > RIW) ? CIW : RIW;
  localparam int CMP_A   = IW + FRAC_BITS + 2;
  localparam int CMP_W   = (CMP_A > POS_W + 2) ? CMP_A : POS_W + 2;
  localparam logic signed [CMP_W-1:0] ONE = CMP_W'(2 ** FRAC_BITS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SWEEP  = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]        state;
  logic [CFG_W-1:0]  canvas_width;
  logic [CFG_W-1:0]  canvas_height;
  logic [CHAR_W-1:0] background_char;

  logic              is_clear;
  logic              filled;
  logic [CHAR_W-1:0] paint_char;
  logic signed [CMP_W-1:0] x_lo, x_hi, x_in_lo, x_in_hi;
  logic signed [CMP_W-1:0] y_lo, y_hi, y_in_lo, y_in_hi;
  logic [CIW-1:0]    col_cnt;
  logic [RIW-1:0]    row_cnt;
  logic [CIW-1:0]    rd_col;
  logic [RIW-1:0]    rd_row;
  logic [1:0]        status_r;
  logic              use_rd;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] mem [DEPTH];

  logic [SZ_W-1:0]   used_cols, used_rows;
  logic              canvas_empty;
  logic              req_fire;
  logic              draw_ok;
  logic              read_out;
  logic              col_last, row_last;
  logic signed [CMP_W-1:0] ci, cj;
  logic signed [CMP_W-1:0] x_ext, y_ext, w_ext, h_ext;
  logic              in_x, in_y, edge_x, edge_y;
  logic              mem_we;
  logic [CHAR_W-1:0] mem_wdata;
  logic              fin_load;

  // canvas size in use, saturated to the memory size
  assign used_cols = (SZ_W'(canvas_width) > SZ_W'(MAX_COLS)) ? SZ_W'(MAX_COLS)
                                                             : SZ_W'(canvas_width);
  assign used_rows = (SZ_W'(canvas_height) > SZ_W'(MAX_ROWS)) ? SZ_W'(MAX_ROWS)
                                                              : SZ_W'(canvas_height);
  assign canvas_empty = (used_cols == '0) || (used_rows == '0);

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign x_ext = {{(CMP_W-POS_W){req.x_pos[POS_W-1]}}, req.x_pos};
  assign y_ext = {{(CMP_W-POS_W){req.y_pos[POS_W-1]}}, req.y_pos};
  assign w_ext = {{(CMP_W-POS_W){req.rect_width[POS_W-1]}}, req.rect_width};
  assign h_ext = {{(CMP_W-POS_W){req.rect_height[POS_W-1]}}, req.rect_height};

  assign draw_ok = !req.rect_width[POS_W-1] && (req.rect_width != '0) &&
                   !req.rect_height[POS_W-1] && (req.rect_height != '0) &&
                   ((req.shape_code == SHAPE_FILLED) || (req.shape_code == SHAPE_OUTLINE));
  assign read_out = (SZ_W'(req.read_col) >= used_cols) || (SZ_W'(req.read_row) >= used_rows);

  assign col_last = (SZ_W'(col_cnt) + SZ_W'(1)) == used_cols;
  assign row_last = (SZ_W'(row_cnt) + SZ_W'(1)) == used_rows;

  // shared cell classifier: cell index scaled to fixed point against the edges
  assign ci = $signed(CMP_W'(col_cnt) << FRAC_BITS);
  assign cj = $signed(CMP_W'(row_cnt) << FRAC_BITS);
  assign in_x   = (ci >= x_lo) && (ci <= x_hi);
  assign in_y   = (cj >= y_lo) && (cj <= y_hi);
  assign edge_x = (ci < x_in_lo) || (ci > x_in_hi);
  assign edge_y = (cj < y_in_lo) || (cj > y_in_hi);

  assign mem_we = (state == ST_SWEEP) &&
                  (is_clear || (in_x && in_y && (filled || edge_x || edge_y)));
  assign mem_wdata = is_clear ? background_char : paint_char;

  assign fin_load = (state == ST_FINISH) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= CANVAS_WIDTH_RST;
      canvas_height   <= CANVAS_HEIGHT_RST;
      background_char <= BACKGROUND_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:    canvas_width    <= cfg_data;
        REG_CANVAS_HEIGHT:   canvas_height   <= cfg_data;
        REG_BACKGROUND_CHAR: background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (req.cmd)
              CMD_CLEAR: state <= canvas_empty ? ST_FINISH : ST_SWEEP;
              CMD_DRAW:  state <= (!draw_ok || canvas_empty) ? ST_FINISH : ST_SWEEP;
              CMD_READ:  state <= read_out ? ST_FINISH : ST_READ;
              default:   state <= ST_FINISH;
            endcase
          end
        end
        ST_SWEEP: begin
          if (col_last && row_last) begin
            state <= ST_FINISH;
          end
        end
        ST_READ: state <= ST_FINISH;
        ST_FINISH: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command item capture and sweep counters
  always_ff @(posedge clk) begin
    if (req_fire) begin
      is_clear   <= (req.cmd == CMD_CLEAR);
      filled     <= (req.shape_code == SHAPE_FILLED);
      paint_char <= req.paint_char;
      x_lo       <= x_ext;
      x_hi       <= x_ext + w_ext;
      x_in_lo    <= x_ext + ONE;
      x_in_hi    <= x_ext + w_ext - ONE;
      y_lo       <= y_ext;
      y_hi       <= y_ext + h_ext;
      y_in_lo    <= y_ext + ONE;
      y_in_hi    <= y_ext + h_ext - ONE;
      rd_col     <= CIW'({8'd0, req.read_col});
      rd_row     <= RIW'({8'd0, req.read_row});
      col_cnt    <= '0;
      row_cnt    <= '0;
      use_rd     <= (req.cmd == CMD_READ) && !read_out;
      if (req.cmd == CMD_DRAW && !draw_ok) begin
        status_r <= STATUS_REJECT;
      end else if (req.cmd == CMD_READ && read_out) begin
        status_r <= STATUS_OUTSIDE;
      end else begin
        status_r <= STATUS_OK;
      end
    end else if (state == ST_SWEEP) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // canvas memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{row_cnt, col_cnt}] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd_data <= mem[{rd_row, rd_col}];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      rsp.status     <= status_r;
      rsp.cell_value <= use_rd ? rd_data : '0;
    end
  end

`include "rectangle_paint_engine_assert.svh"

  `RPE_ASSERT_NOW(a_write_in_sweep, mem_we, state == ST_SWEEP, "canvas write outside sweep")
  `RPE_ASSERT_NOW(a_col_in_range, state == ST_SWEEP, SZ_W'(col_cnt) < used_cols, "column past canvas")
  `RPE_ASSERT_NOW(a_row_in_range, state == ST_SWEEP, SZ_W'(row_cnt) < used_rows, "row past canvas")
  `RPE_ASSERT_NEXT(a_read_one_cycle, state == ST_READ, state == ST_FINISH, "read did not finish")
  `RPE_ASSERT_NOW(a_value_only_ok, rsp_valid && rsp.status != STATUS_OK, rsp.cell_value == '0, "value on failed item")

endmodule

/* tb/sv/tb_rectangle_paint_engine.sv */
// self-checking testbench for rectangle_paint_engine: directed and random
// clear, draw and read items checked against a canvas predictor held here
// depends on rpe_pkg and the rectangle_paint_engine rtl
`timescale 1ns / 1ps

module tb_rectangle_paint_engine;
  import rpe_pkg::*;

  localparam int         ONE         = 1 << FRAC_BITS_DEF;
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam logic [7:0] SHAPE_BAD   = 8'h53;
  localparam int         LONG_HOLD   = 300;
  localparam int         CYCLE_LIMIT = 2000000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  rpe_req_t             req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rpe_rsp_t             rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // predictor state
  logic [CHAR_W-1:0] canvas_mem [MAX_COLS_DEF*MAX_ROWS_DEF];
  logic [CFG_W-1:0]  cur_width  = CANVAS_WIDTH_RST;
  logic [CFG_W-1:0]  cur_height = CANVAS_HEIGHT_RST;
  logic [CHAR_W-1:0] cur_bg     = BACKGROUND_CHAR_RST;
  rpe_rsp_t          rsp_due [$];
  rpe_rsp_t          want_rsp;

  int  mismatches      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  settings_run    = 0;
  int  cycle_count     = 0;
  int  burst_left      = 0;
  bit  steady          = 1'b0;
  bit  req_up          = 1'b0;
  int  hold_asks       = 0;
  int  hold_seen       = 0;
  int  hold_left       = 0;
  int  stall_mode      = 0;
  int  stall_left      = 0;

  rectangle_paint_engine uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $realtime, cycle_count);
      $display("rectangle_paint_engine: mismatch");
      $finish;
    end
  end

  function automatic int used_cols();
    return (cur_width > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cur_width);
  endfunction

  function automatic int used_rows();
    return (cur_height > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(cur_height);
  endfunction

  task automatic apply_to_canvas(input rpe_req_t c, output rpe_rsp_t o);
    int     cols, rows;
    longint x, y, w, h, xe, ye, ci, cj, unit;
    bit     in_rect, band;
    cols = used_cols();
    rows = used_rows();
    unit = ONE;
    o.status = STATUS_OK;
    o.cell_value = '0;
    case (c.cmd)
      CMD_CLEAR: begin
        for (int r = 0; r < rows; r++)
          for (int k = 0; k < cols; k++)
            canvas_mem[r*MAX_COLS_DEF+k] = cur_bg;
      end
      CMD_DRAW: begin
        x = longint'(c.x_pos);
        y = longint'(c.y_pos);
        w = longint'(c.rect_width);
        h = longint'(c.rect_height);
        xe = x + w;
        ye = y + h;
        if (w <= 0 || h <= 0 ||
            (c.shape_code != SHAPE_FILLED && c.shape_code != SHAPE_OUTLINE)) begin
          o.status = STATUS_REJECT;
        end else begin
          for (int r = 0; r < rows; r++) begin
            for (int k = 0; k < cols; k++) begin
              ci = k * unit;
              cj = r * unit;
              in_rect = !(ci < x || ci > xe || cj < y || cj > ye);
              band = (ci - x < unit) || (xe - ci < unit) ||
                     (cj - y < unit) || (ye - cj < unit);
              if (in_rect && (band || c.shape_code == SHAPE_FILLED))
                canvas_mem[r*MAX_COLS_DEF+k] = c.paint_char;
            end
          end
        end
      end
      CMD_READ: begin
        if (c.read_col >= cols || c.read_row >= rows)
          o.status = STATUS_OUTSIDE;
        else
          o.cell_value = canvas_mem[c.read_row*MAX_COLS_DEF+c.read_col];
      end
      default: ;
    endcase
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      results_checked++;
      if (rsp_due.size() == 0) begin
        $display("%0t: item with nothing due, expected none, actual status %0d value %0h",
                 $realtime, rsp.status, rsp.cell_value);
        mismatches++;
      end else begin
        want_rsp = rsp_due.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $realtime, want_rsp.status, rsp.status);
          mismatches++;
        end
        if (rsp.cell_value !== want_rsp.cell_value) begin
          $display("%0t: cell_value expected %0h actual %0h",
                   $realtime, want_rsp.cell_value, rsp.cell_value);
          mismatches++;
        end
      end
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(8, 64);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 1) == 1);
        2: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= (stall_left % 6 != 0);
      endcase
    end
  end

  task automatic drop_req();
    if (req_up) begin
      req_valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic send_cmd(input rpe_req_t item);
    int       gap;
    rpe_rsp_t due;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (steady) gap = 0;
      if (gap > 0) begin
        drop_req();
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= item;
    req_valid <= 1'b1;
    req_up = 1'b1;
    do @(posedge clk); while (!req_ready);
    apply_to_canvas(item, due);
    rsp_due.push_back(due);
    items_sent++;
  endtask

  task automatic wait_all_results();
    drop_req();
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_canvas(input int w, input int h, input logic [7:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data <= w[8:0];
    @(posedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data <= h[8:0];
    @(posedge clk);
    cfg_index <= REG_BACKGROUND_CHAR;
    cfg_data <= {($urandom_range(0, 1) == 1), bg};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width = w[8:0];
    cur_height = h[8:0];
    cur_bg = bg;
    settings_run++;
  endtask

  function automatic rpe_req_t make_cmd(input logic [1:0] cmd);
    rpe_req_t c;
    c.cmd = cmd;
    c.shape_code = CHAR_W'($urandom);
    c.x_pos = POS_W'($urandom);
    c.y_pos = POS_W'($urandom);
    c.rect_width = POS_W'($urandom);
    c.rect_height = POS_W'($urandom);
    c.paint_char = CHAR_W'($urandom);
    c.read_col = 8'($urandom);
    c.read_row = 8'($urandom);
    return c;
  endfunction

  function automatic rpe_req_t make_draw(input logic [7:0] shape, input int x, input int y,
                                         input int w, input int h, input logic [7:0] ch);
    rpe_req_t c;
    c = make_cmd(CMD_DRAW);
    c.shape_code = shape;
    c.x_pos = POS_W'(x);
    c.y_pos = POS_W'(y);
    c.rect_width = POS_W'(w);
    c.rect_height = POS_W'(h);
    c.paint_char = ch;
    return c;
  endfunction

  function automatic rpe_req_t make_read(input int col, input int row);
    rpe_req_t c;
    c = make_cmd(CMD_READ);
    c.read_col = 8'(col);
    c.read_row = 8'(row);
    return c;
  endfunction

  // corner near the canvas, now and then anywhere
  function automatic logic signed [POS_W-1:0] pos_near(input int span);
    if ($urandom_range(0, 7) == 0) return POS_W'($urandom);
    return POS_W'(int'($urandom_range(0, (span + 4) * ONE)) - 2 * ONE);
  endfunction

  function automatic logic signed [POS_W-1:0] size_near(input int span);
    case ($urandom_range(0, 9))
      0: return POS_W'($urandom);
      1: return POS_W'(-int'($urandom_range(0, 3 * ONE)));
      default: return POS_W'($urandom_range(1, (span + 2) * ONE));
    endcase
  endfunction

  function automatic rpe_req_t random_draw();
    rpe_req_t c;
    int       cspan, rspan, pick;
    c = make_cmd(CMD_DRAW);
    cspan = (used_cols() > 0) ? used_cols() : 1;
    rspan = (used_rows() > 0) ? used_rows() : 1;
    pick = $urandom_range(0, 99);
    if (pick < 45) c.shape_code = SHAPE_FILLED;
    else if (pick < 88) c.shape_code = SHAPE_OUTLINE;
    c.x_pos = pos_near(cspan);
    c.y_pos = pos_near(rspan);
    c.rect_width = size_near(cspan);
    c.rect_height = size_near(rspan);
    return c;
  endfunction

  function automatic rpe_req_t random_read();
    rpe_req_t c;
    c = make_cmd(CMD_READ);
    if (used_cols() > 0 && used_rows() > 0 && $urandom_range(0, 5) != 0) begin
      c.read_col = 8'($urandom_range(0, used_cols() - 1));
      c.read_row = 8'($urandom_range(0, used_rows() - 1));
    end
    return c;
  endfunction

  function automatic rpe_req_t random_cmd();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return make_cmd(CMD_CLEAR);
    if (pick < 45) return random_draw();
    if (pick < 92) return random_read();
    return make_cmd(CMD_SPARE);
  endfunction

  // every phase opens with a clear so no read ever hits an unwritten cell
  task automatic run_phase(input int w, input int h, input int n, input bit big);
    logic [7:0] bg;
    wait_all_results();
    bg = 8'($urandom);
    set_canvas(w, h, bg);
    send_cmd(make_cmd(CMD_CLEAR));
    for (int k = 1; k < n; k++) begin
      if (!big) send_cmd(random_cmd());
      else if (k == 1) send_cmd(random_draw());
      else send_cmd(random_read());
    end
  endtask

  task automatic test_clear_and_read();
    wait_all_results();
    set_canvas(8, 6, 8'h2E);
    send_cmd(make_cmd(CMD_CLEAR));
    send_cmd(make_read(0, 0));
    send_cmd(make_read(7, 5));
    send_cmd(make_read(8, 0));
    send_cmd(make_read(0, 6));
    send_cmd(make_read(255, 255));
  endtask

  task automatic test_draw_shapes();
    send_cmd(make_draw(SHAPE_FILLED, 384, 256, 832, 512, 8'h23));
    send_cmd(make_draw(SHAPE_OUTLINE, -128, -256, 1536, 1152, 8'h2A));
    // one column wide sliver
    send_cmd(make_draw(SHAPE_FILLED, 512, 0, 1, 1536, 8'h7C));
    send_cmd(make_draw(SHAPE_OUTLINE, -524288, -524288, 524287, 524287, 8'hFF));
    send_cmd(make_draw(SHAPE_FILLED, 524287, 524287, 524287, 524287, 8'h00));
    send_cmd(make_read(2, 1));
    send_cmd(make_read(3, 2));
    send_cmd(make_read(0, 0));
    send_cmd(make_read(5, 3));
  endtask

  task automatic test_rejected_commands();
    send_cmd(make_draw(SHAPE_FILLED, 0, 0, 0, 2048, 8'h40));
    send_cmd(make_draw(SHAPE_OUTLINE, 0, 0, 2048, 0, 8'h40));
    send_cmd(make_draw(SHAPE_FILLED, 0, 0, -524288, 2048, 8'h40));
    send_cmd(make_draw(SHAPE_OUTLINE, 0, 0, 2048, -1, 8'h40));
    send_cmd(make_draw(8'h00, 0, 0, 2048, 2048, 8'h40));
    send_cmd(make_draw(8'hFF, 0, 0, 2048, 2048, 8'h40));
    send_cmd(make_draw(SHAPE_BAD, 0, 0, 2048, 2048, 8'h40));
    send_cmd(make_cmd(CMD_SPARE));
    send_cmd(make_read(2, 2));
    send_cmd(make_read(4, 4));
  endtask

  task automatic test_canvas_extremes();
    run_phase(1, 1, 9, 1'b0);
    run_phase(511, 1, 9, 1'b0);
    run_phase(1, 511, 9, 1'b0);
    run_phase(0, 5, 5, 1'b0);
    run_phase(7, 0, 5, 1'b0);
    run_phase(256, 256, 5, 1'b1);
  endtask

  // receiver holds off while reads keep coming, so the engine backs up
  task automatic test_output_stall();
    wait_all_results();
    hold_asks++;
    steady = 1'b1;
    repeat (12) send_cmd(random_read());
    steady = 1'b0;
  endtask

  task automatic test_random_canvases();
    repeat (2) run_phase($urandom_range(1, 20), $urandom_range(1, 20), 12, 1'b0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_clear_and_read();
    test_draw_shapes();
    test_rejected_commands();
    test_canvas_extremes();
    test_output_stall();
    test_random_canvases();
    wait_all_results();
    repeat (8) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $display("%0t: %0d items still due, expected none", $realtime, rsp_due.size());
      mismatches++;
    end
    $display("covered %0d items over %0d canvas settings, %0d results checked",
             items_sent, settings_run, results_checked);
    $display("settings ran from empty and single-cell canvases up to the full canvas");
    if (mismatches == 0) begin
      $display("rectangle_paint_engine: match");
    end else begin
      $display("rectangle_paint_engine: mismatch");
    end
    $finish;
  end

endmodule
